@@ design/fflp_pkg.sv @@
package fflp_pkg;

  localparam int DATA_W  = 16;
  localparam int INDEX_W = 7;
  localparam int TOTAL_W = 12;

  localparam logic [TOTAL_W-1:0] COUNT_MAX = 12'd4095;

  typedef enum logic [1:0] {
    STAT_EXISTING  = 2'd0,
    STAT_NEW       = 2'd1,
    STAT_TOO_WIDE  = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [INDEX_W-1:0]    level_index;
    logic [DATA_W-1:0]     used_after;
  } result_t;

endpackage

@@ design/first_fit_level_packer.sv @@
// First-fit level packer.
// Input channel (in_valid/in_ready, in_item_size) takes one request per item.
// Each request yields exactly one result on the output channel (out_valid/
// out_ready): status, level_index, used_after and items_total.
// cfg_we/cfg_wdata set the level width; write it only while the block is idle.
// Each level's used width and item count sit in one synchronous RAM, read
// one level per cycle in index order, written back once when an item is placed.
// A too-wide item goes from acceptance to the result register and the
// finish state, then to the output register; any other item first reads
// levels in index order, 1 to LEVELS of them, until a fit or a new level
// is decided. The next request is taken only once the result has entered
// the output register, so one item is handled at a time, and the sustained
// rate is set by the one RAM read port walking the open levels.
// Reset clears the control state: one open, empty level, count zero, width
// 10. The RAM is not cleared; level 0 is treated as empty until first written.
// When the receiver stalls, the result holds in the output register, the
// next item is still accepted and scanned, and it waits in a finish state
// until the output register frees.
module first_fit_level_packer #(
  parameter int LEVELS = 128,
  parameter int SLOTS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fflp_pkg::DATA_W-1:0]   in_item_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [fflp_pkg::INDEX_W-1:0]  out_level_index,
  output logic [fflp_pkg::DATA_W-1:0]   out_used_after,
  output logic [fflp_pkg::TOTAL_W-1:0]  out_items_total,
  input  logic                          cfg_we,
  input  logic [fflp_pkg::DATA_W-1:0]   cfg_wdata
);
  import fflp_pkg::*;

  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(LEVELS + 1);
  localparam int FW = $clog2(SLOTS + 1);
  localparam int MW = DATA_W + FW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [MW-1:0] mem [LEVELS];
  logic [MW-1:0] rd_data_r;

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      chk_r, chk_nxt;
  logic [DATA_W-1:0]  size_r, size_nxt;
  logic [DATA_W-1:0]  width_r, width_nxt;
  logic [CW-1:0]      open_r, open_nxt;
  logic               lvl0_ok_r, lvl0_ok_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic               in_acc, out_free;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [MW-1:0]      wr_data;
  logic [DATA_W-1:0]  lv_used;
  logic [FW-1:0]      lv_fill;
  logic [DATA_W:0]    sum;
  logic               fits, last, full;
  logic [CW-1:0]      chk_ext;
  logic [TOTAL_W-1:0] count_inc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign chk_ext   = CW'(chk_r);
  assign last      = (chk_ext + CW'(1)) == open_r;
  assign full      = (open_r == CW'(LEVELS));
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + TOTAL_W'(1);

  always_comb begin
    if ((chk_r == AW'(0)) && !lvl0_ok_r) begin
      lv_used = '0;
      lv_fill = '0;
    end else begin
      lv_used = rd_data_r[MW-1:FW];
      lv_fill = rd_data_r[FW-1:0];
    end
  end

  assign sum  = {1'b0, lv_used} + {1'b0, size_r};
  assign fits = (sum <= {1'b0, width_r}) && (lv_fill < FW'(SLOTS));

  always_comb begin
    state_nxt     = state_r;
    chk_nxt       = chk_r;
    size_nxt      = size_r;
    width_nxt     = width_r;
    open_nxt      = open_r;
    lvl0_ok_nxt   = lvl0_ok_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_total_nxt = out_total_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = chk_r;
    wr_data       = {sum[DATA_W-1:0], lv_fill + FW'(1)};

    if (cfg_we) begin
      width_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          size_nxt = in_item_size;
          chk_nxt  = '0;
          if (in_item_size > width_r) begin
            res_nxt   = '{status: STAT_TOO_WIDE, level_index: '0, used_after: '0};
            state_nxt = S_FIN;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fits) begin
          wr_en     = 1'b1;
          count_nxt = count_inc;
          res_nxt   = '{status: STAT_EXISTING, level_index: INDEX_W'(chk_r),
                        used_after: sum[DATA_W-1:0]};
          if (chk_r == AW'(0)) begin
            lvl0_ok_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end else if (last) begin
          if (full) begin
            res_nxt = '{status: STAT_EXHAUSTED, level_index: '0, used_after: '0};
          end else begin
            wr_en     = 1'b1;
            wr_addr   = AW'(open_r);
            wr_data   = {size_r, FW'(1)};
            open_nxt  = open_r + CW'(1);
            count_nxt = count_inc;
            res_nxt   = '{status: STAT_NEW, level_index: INDEX_W'(open_r),
                          used_after: size_r};
          end
          state_nxt = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(chk_ext + CW'(1));
          chk_nxt = AW'(chk_ext + CW'(1));
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_total_nxt = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= DATA_W'(10);
      open_r      <= CW'(1);
      lvl0_ok_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      open_r      <= open_nxt;
      lvl0_ok_r   <= lvl0_ok_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r       <= chk_nxt;
    size_r      <= size_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_level_index = out_res_r.level_index;
  assign out_used_after  = out_res_r.used_after;
  assign out_items_total = out_total_r;

endmodule

@@ design/fflp_checker.sv @@
module fflp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [fflp_pkg::INDEX_W-1:0]  out_level_index,
  input logic [fflp_pkg::DATA_W-1:0]   out_used_after,
  input logic [fflp_pkg::TOTAL_W-1:0]  out_items_total
);
  import fflp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_level_index) && $stable(out_used_after) && $stable(out_items_total))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_not_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_TOO_WIDE || out_status == STAT_EXHAUSTED) |->
      out_level_index == '0 && out_used_after == '0)
    else $error("unplaced item reports a level");

  a_placed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EXISTING || out_status == STAT_NEW) |->
      out_items_total != '0)
    else $error("placed item with zero total");

endmodule

bind first_fit_level_packer fflp_checker u_fflp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_level_index (out_level_index),
  .out_used_after  (out_used_after),
  .out_items_total (out_items_total)
);
